### rtl/dqe_pkg.sv
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared types and codes for the double-ended score queue.
// ----------------------------------------------------------------------------
package dqe_pkg;

   localparam int FILL_W = 7;
   localparam int POS_W  = 7;
   localparam int VAL_W  = 32;

   // request mode codes
   localparam logic [2:0] MODE_PUSH_HEAD = 3'd0;
   localparam logic [2:0] MODE_PUSH_TAIL = 3'd1;
   localparam logic [2:0] MODE_POP_HEAD  = 3'd2;
   localparam logic [2:0] MODE_POP_TAIL  = 3'd3;
   localparam logic [2:0] MODE_READ_END  = 3'd4;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef enum logic [2:0] {
      OP_PUSH_HEAD = 3'd0,
      OP_PUSH_TAIL = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_POP_TAIL  = 3'd3,
      OP_READ_END  = 3'd4,
      OP_NOP       = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0]              mode;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        position;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [VAL_W-1:0] read_value;
      logic [FILL_W-1:0]       fill_count;
   } rsp_type;

   typedef struct packed {
      op_type                  op;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        position;
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

endpackage

### rtl/dqe_ram.sv
// ----------------------------------------------------------------------------
// dqe_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dqe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dqe_fifo.sv
// ----------------------------------------------------------------------------
// dqe_fifo
// Small register FIFO with full/empty flags, show-ahead output.
// ----------------------------------------------------------------------------
module dqe_fifo #(
   parameter int WIDTH = 8,
   parameter int LOG2_DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int ENTRIES = 2 ** LOG2_DEPTH;

   logic [WIDTH-1:0]      mem_ff [ENTRIES];
   logic [LOG2_DEPTH-1:0] wptr_ff, wptr_in;
   logic [LOG2_DEPTH-1:0] rptr_ff, rptr_in;
   logic [LOG2_DEPTH:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == (LOG2_DEPTH+1)'(ENTRIES));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

### rtl/dqe_front.sv
// ----------------------------------------------------------------------------
// dqe_front
// Accepts requests, decodes the mode and queues commands for the back end.
// ----------------------------------------------------------------------------
module dqe_front
   import dqe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_take
);

   cmd_type                cmd_dec;
   logic [$bits(cmd_type)-1:0] cmd_raw;
   logic                   cmd_empty;

   always_comb begin
      cmd_dec.value    = req_data.value;
      cmd_dec.position = req_data.position;
      case (req_data.mode)
         MODE_PUSH_HEAD: cmd_dec.op = OP_PUSH_HEAD;
         MODE_PUSH_TAIL: cmd_dec.op = OP_PUSH_TAIL;
         MODE_POP_HEAD:  cmd_dec.op = OP_POP_HEAD;
         MODE_POP_TAIL:  cmd_dec.op = OP_POP_TAIL;
         MODE_READ_END:  cmd_dec.op = OP_READ_END;
         default:        cmd_dec.op = OP_NOP;
      endcase
   end

   dqe_fifo #(
      .WIDTH      ($bits(cmd_type)),
      .LOG2_DEPTH (1)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_dec),
      .full      (req_full),
      .pop       (cmd_take),
      .pop_data  (cmd_raw),
      .empty     (cmd_empty)
   );

   assign cmd_data  = cmd_type'(cmd_raw);
   assign cmd_valid = !cmd_empty;

endmodule

### rtl/dqe_back.sv
// ----------------------------------------------------------------------------
// dqe_back
// Executes deque commands on the ring store and queues the responses.
// ----------------------------------------------------------------------------
module dqe_back
   import dqe_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd_data,
   output logic    cmd_take,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int SUMW = (AW + 1 > POS_W) ? AW + 1 : POS_W;

   state_type       state_ff, state_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;

   logic            rsp_push, rsp_full;
   rsp_type         rsp_new;
   logic [$bits(rsp_type)-1:0] rsp_raw;

   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   logic [VAL_W-1:0] ram_rdata;

   logic            is_full, is_empty, pos_bad;
   logic [AW-1:0]   head_dec, head_inc, tail_next;
   logic [SUMW-1:0] tail_sum, read_sum;
   logic [AW-1:0]   read_slot;

   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign pos_bad  = (cmd_data.position == '0) ||
                     (SUMW'(cmd_data.position) > SUMW'(count_ff));

   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign tail_sum  = SUMW'(head_ff) + SUMW'(count_ff);
   assign tail_next = (tail_sum >= SUMW'(DEPTH)) ? AW'(tail_sum - SUMW'(DEPTH))
                                                 : AW'(tail_sum);
   // pos lies in 1..count here, so the sum stays below twice the depth
   assign read_sum  = tail_sum - SUMW'(cmd_data.position);
   assign read_slot = (read_sum >= SUMW'(DEPTH)) ? AW'(read_sum - SUMW'(DEPTH))
                                                 : AW'(read_sum);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      cmd_take   = 1'b0;
      rsp_push   = 1'b0;
      rsp_new    = '{status: ST_OK, read_value: '0, fill_count: FILL_W'(count_ff)};
      ram_we     = 1'b0;
      ram_waddr  = tail_next;
      ram_re     = 1'b0;
      ram_raddr  = read_slot;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_take = 1'b1;
               rsp_push = 1'b1;
               case (cmd_data.op)
                  OP_PUSH_HEAD: begin
                     if (is_full) begin
                        rsp_new.status = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = head_dec;
                        head_in   = head_dec;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  OP_PUSH_TAIL: begin
                     if (is_full) begin
                        rsp_new.status = ST_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP_HEAD: begin
                     if (is_empty) begin
                        rsp_new.status = ST_EMPTY;
                     end else begin
                        head_in  = head_inc;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_POP_TAIL: begin
                     if (is_empty) begin
                        rsp_new.status = ST_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_READ_END: begin
                     if (pos_bad) begin
                        rsp_new.status = ST_RANGE;
                     end else begin
                        // response waits for the registered RAM read and is pushed from S_READ
                        rsp_push = 1'b0;
                        ram_re   = 1'b1;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_new.fill_count = FILL_W'(count_in);
            end
         end
         S_READ: begin
            rsp_push           = 1'b1;
            rsp_new.read_value = ram_rdata;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   dqe_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd_data.value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   dqe_fifo #(
      .WIDTH      ($bits(rsp_type)),
      .LOG2_DEPTH (1)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_raw),
      .empty     (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_raw);

endmodule

### rtl/deque_with_index_from_end.sv
// ----------------------------------------------------------------------------
// deque_with_index_from_end
// Double-ended queue of signed 32-bit scores in a DEPTH-entry ring store.
// ----------------------------------------------------------------------------
// Usage:
//   Request side looks like a FIFO write port: drive req_data and raise
//   req_push; the request is taken on a clock edge where req_full is low.
//   req_data.mode picks push head, push tail, pop head, pop tail or read
//   at a position counted from the tail (1 = tail).
//   Every request gives exactly one response, in order, on rsp_data while
//   rsp_empty is low; raise rsp_pop to take it.
//   Path: a taken request waits in the command queue, is executed and
//   its response is written to the response queue; a successful read
//   also passes through the registered read port and the S_READ state.
//   Throughput: one request per cycle while the response queue has room,
//   except a successful read, which holds the executor in S_READ because
//   the ring store has a registered read port.
//   Two-entry command and response queues decouple the sides; if the
//   response consumer stalls, up to two responses and two commands are
//   buffered before req_full rises.
//   Reset (synchronous, active high) empties both queues and the deque;
//   the ring store itself is not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
module deque_with_index_from_end
   import dqe_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   // decoded command channel between front and back end
   logic    cmd_valid;
   cmd_type cmd_data;
   logic    cmd_take;

   // front end: decode the mode, buffer commands
   dqe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   // back end: head/count state, ring store, response queue
   dqe_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // a rejected push only happens on a full deque
   a_full_status : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == ST_FULL) |->
         rsp_data.fill_count == FILL_W'(DEPTH))
      else $error("full status with count below depth");

   // a rejected pop only happens on an empty deque
   a_empty_status : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == ST_EMPTY) |-> rsp_data.fill_count == '0)
      else $error("empty status with nonzero count");

   // only a successful read returns data
   a_value_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != ST_OK) |-> rsp_data.read_value == '0)
      else $error("read value on failed request");

   // the reported count never goes past the ring size
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.fill_count <= FILL_W'(DEPTH))
      else $error("fill count above depth");

endmodule

### tb/deque_with_index_from_end_tb.sv
// ----------------------------------------------------------------------------
// deque_with_index_from_end_tb
// Drives random and hand-picked requests into the double-ended score queue
// and checks every response against a behavioral ring-buffer predictor.
// ----------------------------------------------------------------------------
module deque_with_index_from_end_tb
   import dqe_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = 64;
   localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
   localparam int RANDOM_ITEMS  = 400;
   localparam int IDLE_PCT      = 23;
   localparam int MAX_REPORTS   = 10;

   // Traffic mixes for the random part: grow the queue toward full, shrink it
   // toward empty, or churn around the current level.
   typedef enum {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_type;

   // -------------------------------------------------------------------------
   // Scoreboard: owns a shadow copy of the deque and the queue of responses
   // still owed by the block.
   // -------------------------------------------------------------------------
   class deque_scoreboard;
      logic signed [VAL_W-1:0] ring [DEPTH];
      int unsigned head;
      int unsigned count;
      rsp_type     owed_q [$];
      int unsigned errors;

      function new();
         head   = 0;
         count  = 0;
         errors = 0;
      endfunction

      // Apply one accepted request to the shadow deque and queue its response.
      function void note(req_type r);
         rsp_type rsp;
         rsp.status     = ST_OK;
         rsp.read_value = '0;
         case (r.mode)
            MODE_PUSH_HEAD: begin
               if (count >= DEPTH) begin
                  rsp.status = ST_FULL;
               end else begin
                  head       = (head + DEPTH - 1) % DEPTH;
                  ring[head] = r.value;
                  count++;
               end
            end
            MODE_PUSH_TAIL: begin
               if (count >= DEPTH) begin
                  rsp.status = ST_FULL;
               end else begin
                  ring[(head + count) % DEPTH] = r.value;
                  count++;
               end
            end
            MODE_POP_HEAD: begin
               if (count == 0) begin
                  rsp.status = ST_EMPTY;
               end else begin
                  head = (head + 1) % DEPTH;
                  count--;
               end
            end
            MODE_POP_TAIL: begin
               if (count == 0) begin
                  rsp.status = ST_EMPTY;
               end else begin
                  count--;
               end
            end
            MODE_READ_END: begin
               // position 1 is the tail, position count is the head
               if (r.position == 0 || r.position > count) begin
                  rsp.status = ST_RANGE;
               end else begin
                  rsp.read_value = ring[(head + count - r.position) % DEPTH];
               end
            end
            default: begin
            end
         endcase
         rsp.fill_count = FILL_W'(count);
         owed_q.push_back(rsp);
      endfunction

      function void check(rsp_type got);
         rsp_type want;
         if (owed_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected response: status=%0d value=%0d fill=%0d",
                        got.status, got.read_value, got.fill_count);
            return;
         end
         want = owed_q.pop_front();
         if (got.status !== want.status || got.read_value !== want.read_value ||
             got.fill_count !== want.fill_count) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display({"mismatch: expected status=%0d value=%0d fill=%0d,",
                         " got status=%0d value=%0d fill=%0d"},
                        want.status, want.read_value, want.fill_count,
                        got.status, got.read_value, got.fill_count);
         end
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic    clock;
   logic    reset;
   logic    req_push;
   req_type req_data;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   deque_with_index_from_end #(.DEPTH(DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   deque_scoreboard sb = new();

   // When set, neither side inserts bubbles: back-to-back traffic window.
   bit steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Response side: pop with random stalls, except in the steady window.
   // -------------------------------------------------------------------------
   initial begin
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_pop <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Responses are checked where they are taken: edge with pop high, empty low.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check(rsp_data);
   end

   // -------------------------------------------------------------------------
   // Watchdog: any edge with a handshake on either side restarts the count.
   // -------------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no request or response moved for %0d cycles", STALL_LIMIT);
         $display("deque_with_index_from_end_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Request side helpers
   // -------------------------------------------------------------------------
   function automatic req_type make_request(logic [2:0] mode, logic signed [VAL_W-1:0] value,
                                            logic [POS_W-1:0] position);
      req_type r;
      r.mode     = mode;
      r.value    = value;
      r.position = position;
      return r;
   endfunction

   // Random request shaped by the current mix. Fields a mode ignores still get
   // random content. Reads mostly hit the live range, the rest probe its edges or stay random.
   function automatic req_type pick_request(mix_type mix, int unsigned held);
      req_type     r;
      int unsigned roll;
      int unsigned push_pct;
      int unsigned pop_pct;
      r.value    = $urandom();
      r.position = POS_W'($urandom_range(127));
      roll       = $urandom_range(99);
      case (mix)
         MIX_GROW: begin
            push_pct = 80;
            pop_pct  = 5;
         end
         MIX_SHRINK: begin
            push_pct = 5;
            pop_pct  = 75;
         end
         default: begin
            push_pct = 35;
            pop_pct  = 30;
         end
      endcase
      if (roll < 3) begin
         r.mode = 3'($urandom_range(7, 5));       // unused mode codes
      end else if (roll < 3 + push_pct) begin
         r.mode = $urandom_range(1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD;
      end else if (roll < 3 + push_pct + pop_pct) begin
         r.mode = $urandom_range(1) ? MODE_POP_TAIL : MODE_POP_HEAD;
      end else begin
         r.mode = MODE_READ_END;
         if (held != 0 && $urandom_range(99) < 80) begin
            r.position = POS_W'($urandom_range(held, 1));
         end else begin
            case ($urandom_range(2))
               0: r.position = '0;
               1: r.position = POS_W'(held + 1);
               default: begin
               end
            endcase
         end
      end
      return r;
   endfunction

   // Offer one request and hold it until taken; then maybe leave bubbles.
   // Each further idle cycle is drawn with the same odds, so about IDLE_PCT
   // of the request-side cycles are idle.
   // The predictor is updated on the accepting edge, before any response to
   // this request can show up.
   task automatic send_request(input req_type r);
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      sb.note(r);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Drop push and hold off until every owed response has been popped.
   task automatic drain_responses();
      req_push <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      req_type directed_q [$];
      mix_type mix;

      reset    <= 1'b1;
      req_push <= 1'b0;
      req_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty-queue corner cases: pops and reads must be rejected, unused
      // modes answer OK and touch nothing.
      directed_q.push_back(make_request(MODE_POP_HEAD, 32'sd5, 7'd0));
      directed_q.push_back(make_request(MODE_POP_TAIL, -32'sd5, 7'd127));
      directed_q.push_back(make_request(MODE_READ_END, 32'sd0, 7'd0));
      directed_q.push_back(make_request(MODE_READ_END, 32'sd0, 7'd1));
      directed_q.push_back(make_request(3'd5, 32'sh7fffffff, 7'd64));
      directed_q.push_back(make_request(3'd6, 32'sh80000000, 7'd1));
      directed_q.push_back(make_request(3'd7, -32'sd1, 7'd127));
      // Extreme values from both ends; head pointer wraps below slot zero.
      directed_q.push_back(make_request(MODE_PUSH_TAIL, 32'sh7fffffff, 7'd0));
      directed_q.push_back(make_request(MODE_PUSH_HEAD, 32'sh80000000, 7'd127));
      directed_q.push_back(make_request(MODE_PUSH_TAIL, 32'sd0, 7'd64));
      directed_q.push_back(make_request(MODE_PUSH_HEAD, -32'sd1, 7'd0));
      // Every live position, then just past the head, then far out of range, then position zero.
      directed_q.push_back(make_request(MODE_READ_END, 32'sd0, 7'd1));
      directed_q.push_back(make_request(MODE_READ_END, 32'sd0, 7'd2));
      directed_q.push_back(make_request(MODE_READ_END, 32'sd0, 7'd3));
      directed_q.push_back(make_request(MODE_READ_END, 32'sd0, 7'd4));
      directed_q.push_back(make_request(MODE_READ_END, 32'sd0, 7'd5));
      directed_q.push_back(make_request(MODE_READ_END, -32'sd1, 7'd127));
      directed_q.push_back(make_request(MODE_READ_END, 32'sd0, 7'd0));
      // Shrink from both ends and look at what is left.
      directed_q.push_back(make_request(MODE_POP_HEAD, 32'sd0, 7'd0));
      directed_q.push_back(make_request(MODE_POP_TAIL, 32'sd0, 7'd0));
      directed_q.push_back(make_request(MODE_READ_END, 32'sd0, 7'd1));
      directed_q.push_back(make_request(MODE_READ_END, 32'sd0, 7'd2));
      directed_q.push_back(make_request(MODE_READ_END, 32'sd0, 7'd3));

      foreach (directed_q[k])
         send_request(directed_q[k]);
      drain_responses();

      // Random part in blocks of 50. Two grow blocks push through full, two
      // shrink blocks drain through empty, then the mix is left to chance.
      // Items 150..249 run with no bubbles on either side.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) begin
            case (i / 50)
               0, 1:    mix = MIX_GROW;
               2, 3:    mix = MIX_SHRINK;
               default: mix = mix_type'($urandom_range(2));
            endcase
         end
         steady = (i >= 150 && i < 250);
         if (i == 300)
            drain_responses();
         send_request(pick_request(mix, sb.count));
      end

      // Wait out every owed response, then a few more edges to catch strays.
      drain_responses();
      repeat (10) @(posedge clock);

      if (sb.errors == 0)
         $display("deque_with_index_from_end_tb OK");
      else
         $display("deque_with_index_from_end_tb NOT OK");
      $finish;
   end

endmodule
